[hdl/rpfc_pkg.sv]
`timescale 1ns / 1ps
package rpfc_pkg;

  // Field and bus widths
  localparam int unsigned WidthW   = 12;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned OutUserW = 2;

  // Stick deadband and gain
  localparam logic [WidthW-1:0] StickBandLo = 12'd1400;
  localparam logic [WidthW-1:0] StickBandHi = 12'd1600;
  localparam logic [WidthW-1:0] StickCenter = 12'd1500;
  // (84*d + 152000) / 100 is 4*(21*d + 38000) / 100, so divide by 25
  localparam logic signed [18:0] StickOffsetDiv4 = 19'sd38000;
  // ceil(2^22 / 25); exact floor division for values below 2^17
  localparam logic [17:0] Recip25   = 18'd167773;
  localparam int unsigned Recip25Sh = 22;

  // Door timer and save level
  localparam logic [TimeW-1:0]  ShortPressMin  = 32'd50;
  localparam logic [TimeW-1:0]  ShortPressMax  = 32'd300;
  localparam logic [WidthW-1:0] SaveSetLevel   = 12'd1300;
  localparam logic [WidthW-1:0] SaveClearLevel = 12'd2140;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BTN_LOW   = 3'd0,
    CFG_BTN_HIGH  = 3'd1,
    CFG_DOOR_LOW  = 3'd2,
    CFG_HOLD_TIME = 3'd3,
    CFG_LOW_CODE  = 3'd4,
    CFG_HIGH_CODE = 3'd5,
    CFG_RANGE_MIN = 3'd6,
    CFG_RANGE_MAX = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [WidthW-1:0] btn_low_th;
    logic [WidthW-1:0] btn_high_th;
    logic [WidthW-1:0] door_low_th;
    logic [HoldW-1:0]  hold_time;
    logic [WidthW-1:0] low_code;
    logic [WidthW-1:0] high_code;
    logic [WidthW-1:0] range_min;
    logic [WidthW-1:0] range_max;
  } cfg_t;

  typedef struct packed {
    logic [WidthW-1:0] steer;
    logic [WidthW-1:0] throttle;
    logic [WidthW-1:0] zero_turn;
    logic [WidthW-1:0] relay;
    logic [WidthW-1:0] mode;
    logic [WidthW-1:0] door;
  } frame_t;

  typedef struct packed {
    logic              ok;
    logic [WidthW-1:0] steer;
    logic [WidthW-1:0] throttle;
    logic [WidthW-1:0] zero_turn;
    logic [WidthW-1:0] relay;
    logic [WidthW-1:0] mode;
    logic [WidthW-1:0] door_code;
  } chan_res_t;

  typedef struct packed {
    logic latch_next;
    logic save_flag;
    logic parity_next;
  } door_stat_t;

endpackage

[hdl/rpfc_cfg.sv]
`timescale 1ns / 1ps
module rpfc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [rpfc_pkg::CfgIdxW-1:0]  index_i,
  input  logic [rpfc_pkg::CfgDataW-1:0] wdata_i,
  output rpfc_pkg::cfg_t                cfg_o
);
  import rpfc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write onto one register
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(index_i))
        CFG_BTN_LOW:   cfg_d.btn_low_th  = wdata_i[WidthW-1:0];
        CFG_BTN_HIGH:  cfg_d.btn_high_th = wdata_i[WidthW-1:0];
        CFG_DOOR_LOW:  cfg_d.door_low_th = wdata_i[WidthW-1:0];
        CFG_HOLD_TIME: cfg_d.hold_time   = wdata_i[HoldW-1:0];
        CFG_LOW_CODE:  cfg_d.low_code    = wdata_i[WidthW-1:0];
        CFG_HIGH_CODE: cfg_d.high_code   = wdata_i[WidthW-1:0];
        CFG_RANGE_MIN: cfg_d.range_min   = wdata_i[WidthW-1:0];
        CFG_RANGE_MAX: cfg_d.range_max   = wdata_i[WidthW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.btn_low_th  <= 12'd1300;
      cfg_q.btn_high_th <= 12'd1700;
      cfg_q.door_low_th <= 12'd1300;
      cfg_q.hold_time   <= 16'd1000;
      cfg_q.low_code    <= 12'd1000;
      cfg_q.high_code   <= 12'd2000;
      cfg_q.range_min   <= 12'd900;
      cfg_q.range_max   <= 12'd2100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/rpfc_chan.sv]
`timescale 1ns / 1ps
module rpfc_chan (
  input  rpfc_pkg::frame_t    frame_i,
  input  rpfc_pkg::cfg_t      cfg_i,
  output rpfc_pkg::chan_res_t res_o
);
  import rpfc_pkg::*;

  // Snap a stick to center inside the open deadband
  function automatic logic [WidthW-1:0] deadband(input logic [WidthW-1:0] w);
    return (w > StickBandLo && w < StickBandHi) ? StickCenter : w;
  endfunction

  // Gain of 0.84 about center, offset to 1520, truncated and clamped at zero
  function automatic logic [WidthW-1:0] scale(input logic [WidthW-1:0] w,
                                              input logic invert);
    logic signed [13:0] d;
    logic signed [18:0] dx;
    logic signed [18:0] y;
    logic [34:0]        prod;
    logic [12:0]        q;
    logic [WidthW-1:0]  r;
    d    = invert ? ($signed({2'b00, StickCenter}) - $signed({2'b00, w}))
                  : ($signed({2'b00, w}) - $signed({2'b00, StickCenter}));
    dx   = 19'(d);
    y    = (dx <<< 4) + (dx <<< 2) + dx + StickOffsetDiv4;
    prod = 35'(y[16:0]) * 35'(Recip25);
    q    = prod[Recip25Sh +: 13];
    if (y <= 19'sd0) begin
      r = '0;
    end else if (q[12]) begin
      r = '1;
    end else begin
      r = q[WidthW-1:0];
    end
    return r;
  endfunction

  // Map a button width onto low code, high code or zero
  function automatic logic [WidthW-1:0] btn_code(input logic [WidthW-1:0] w,
                                                 input logic [WidthW-1:0] lo_th,
                                                 input cfg_t c);
    logic [WidthW-1:0] r;
    if (w < lo_th) begin
      r = c.low_code;
    end else if (w > c.btn_high_th) begin
      r = c.high_code;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic in_range(input logic [WidthW-1:0] w, input cfg_t c);
    return (w >= c.range_min) && (w <= c.range_max);
  endfunction

  logic [WidthW-1:0] steer_db, throttle_db;

  assign steer_db    = deadband(frame_i.steer);
  assign throttle_db = deadband(frame_i.throttle);

  // Range check on all six widths
  assign res_o.ok = in_range(steer_db, cfg_i) && in_range(throttle_db, cfg_i) &&
                    in_range(frame_i.zero_turn, cfg_i) && in_range(frame_i.relay, cfg_i) &&
                    in_range(frame_i.mode, cfg_i) && in_range(frame_i.door, cfg_i);

  assign res_o.steer     = scale(steer_db, 1'b0);
  assign res_o.throttle  = scale(throttle_db, 1'b1);
  assign res_o.zero_turn = btn_code(frame_i.zero_turn, cfg_i.btn_low_th, cfg_i);
  assign res_o.relay     = btn_code(frame_i.relay, cfg_i.btn_low_th, cfg_i);
  assign res_o.mode      = btn_code(frame_i.mode, cfg_i.btn_low_th, cfg_i);
  assign res_o.door_code = btn_code(frame_i.door, cfg_i.door_low_th, cfg_i);

endmodule

[hdl/rpfc_door.sv]
`timescale 1ns / 1ps
module rpfc_door (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [rpfc_pkg::WidthW-1:0] code_i,
  input  logic [rpfc_pkg::TimeW-1:0]  now_i,
  input  rpfc_pkg::cfg_t              cfg_i,
  output rpfc_pkg::door_stat_t        stat_o
);
  import rpfc_pkg::*;

  logic             latch_q, latch_d;
  logic             save_q, save_d;
  logic             press_seen_q, press_seen_d;
  logic             release_seen_q, release_seen_d;
  logic             pending_q, pending_d;
  logic             parity_q, parity_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic [TimeW-1:0] release_time_q, release_time_d;
  logic [TimeW-1:0] rel_t, dlt;

  // Press/release timer, advanced once per good frame
  always_comb begin
    latch_d        = latch_q;
    save_d         = save_q;
    press_seen_d   = press_seen_q;
    release_seen_d = release_seen_q;
    pending_d      = pending_q;
    parity_d       = parity_q;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    rel_t          = release_seen_q ? release_time_q : now_i;
    dlt            = rel_t - press_time_q;
    if (step_i) begin
      parity_d = ~parity_q;
      if (code_i == cfg_i.high_code) begin
        if (!press_seen_q) begin
          pending_d      = 1'b1;
          press_seen_d   = 1'b1;
          press_time_d   = now_i;
          release_seen_d = 1'b0;
        end
      end else if (code_i == cfg_i.low_code) begin
        press_seen_d = 1'b0;
        if (!release_seen_q) begin
          release_time_d = now_i;
          release_seen_d = 1'b1;
        end
        if (pending_q && dlt >= TimeW'(cfg_i.hold_time)) begin
          latch_d = ~latch_q;
        end
        if (pending_q && dlt > ShortPressMin && dlt < ShortPressMax) begin
          save_d = ~save_q;
        end
        pending_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q        <= 1'b0;
      save_q         <= 1'b0;
      press_seen_q   <= 1'b0;
      release_seen_q <= 1'b0;
      pending_q      <= 1'b0;
      parity_q       <= 1'b0;
      press_time_q   <= '0;
      release_time_q <= '0;
    end else begin
      latch_q        <= latch_d;
      save_q         <= save_d;
      press_seen_q   <= press_seen_d;
      release_seen_q <= release_seen_d;
      pending_q      <= pending_d;
      parity_q       <= parity_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
    end
  end

  // Save level reads the flag before this frame's update
  assign stat_o.latch_next  = latch_d;
  assign stat_o.save_flag   = save_q;
  assign stat_o.parity_next = parity_d;

endmodule

[hdl/rc_pulse_frame_conditioner_core.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake                    Payload
// s_axis   in         s_axis_tvalid/s_axis_tready  one frame of six widths and a ms tick
// m_axis   out        m_axis_tvalid/m_axis_tready  conditioned frame, error and parity flags
// cfg      in         cfg_we_i                     register index and write data
//
// A frame is taken into an input register, worked by combinational logic and held in an
// output register; the result word is registered there when the output is free or taken.
// Both registers move on the same edge, so a frame per cycle holds while m_axis takes words;
// a stall on m_axis holds the result register and fills the input register before
// s_axis_tready drops.
// Reset clears the handshake, the door timer state and loads register defaults.
module rc_pulse_frame_conditioner_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // steer, throttle, zero_turn, relay, mode, door width (12b each), now_ms (32b)
  input  logic [rpfc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // steer, throttle, zero_turn, relay, mode, save_level, door_level (12b each), 4b zero
  output logic [rpfc_pkg::OutDataW-1:0] m_axis_tdata,
  // packet_error, frame_parity
  output logic [rpfc_pkg::OutUserW-1:0] m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [rpfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpfc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rpfc_pkg::*;

  cfg_t       cfg;
  chan_res_t  chan;
  door_stat_t door;
  frame_t     frame;

  logic                in_vld_q, in_vld_d;
  logic [InDataW-1:0]  in_data_q;
  logic                out_vld_q, out_vld_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [OutUserW-1:0] out_user_q, out_user_d;
  logic                adv;
  logic [WidthW-1:0]   save_lvl, door_lvl;

  rpfc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Unpack the held word, lowest field first
  assign frame.steer     = in_data_q[11:0];
  assign frame.throttle  = in_data_q[23:12];
  assign frame.zero_turn = in_data_q[35:24];
  assign frame.relay     = in_data_q[47:36];
  assign frame.mode      = in_data_q[59:48];
  assign frame.door      = in_data_q[71:60];

  rpfc_chan u_chan (
    .frame_i (frame),
    .cfg_i   (cfg),
    .res_o   (chan)
  );

  rpfc_door u_door (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv && chan.ok),
    .code_i (chan.door_code),
    .now_i  (in_data_q[103:72]),
    .cfg_i  (cfg),
    .stat_o (door)
  );

  // Move a word from the input register to the output register
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  assign in_vld_d  = (s_axis_tvalid && s_axis_tready) ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign out_vld_d = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  assign save_lvl = door.save_flag ? SaveSetLevel : SaveClearLevel;
  assign door_lvl = door.latch_next ? cfg.low_code : cfg.high_code;

  // Build the result word; a rejected frame shows only the error flag
  always_comb begin
    if (chan.ok) begin
      out_data_d = {4'b0000, door_lvl, save_lvl, chan.mode, chan.relay,
                    chan.zero_turn, chan.throttle, chan.steer};
      out_user_d = {door.parity_next, 1'b0};
    end else begin
      out_data_d = '0;
      out_user_d = 2'b01;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
    end
    if (adv) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[hdl/rpfc_checker.sv]
`timescale 1ns / 1ps
module rpfc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rpfc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [rpfc_pkg::OutUserW-1:0] m_axis_tuser
);
  import rpfc_pkg::*;

  logic last_par_q;
  logic out_take;

  assign out_take = m_axis_tvalid && m_axis_tready;

  // Track the parity of the last good word delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_par_q <= 1'b0;
    end else if (out_take && !m_axis_tuser[0]) begin
      last_par_q <= m_axis_tuser[1];
    end
  end

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A rejected frame carries nothing but the error flag
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("rejected frame with nonzero payload");

  // Parity flips from one good word to the next
  a_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !m_axis_tuser[0] |-> m_axis_tuser[1] != last_par_q)
    else $error("frame parity did not toggle");

  // Save level is one of its two values on a good word
  a_save: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[71:60] == SaveSetLevel || m_axis_tdata[71:60] == SaveClearLevel)
    else $error("bad save level");

  // A sink that takes words never stalls the source
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

bind rc_pulse_frame_conditioner_core rpfc_checker u_rpfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
